// File: rtl/core/mm_pkg.sv
// Shared types and constants of the matrix multiply block.
// Stream field widths, bit offsets, request kinds and register indexes.
// Depends on nothing; used by the top level and its checker.
`default_nettype none

package mm_pkg;

  // Field widths of the fixed stream format.
  localparam int DATA_W    = 32;
  localparam int IDX_W     = 3;
  localparam int KIND_W    = 2;
  localparam int TDATA_W   = 40;
  localparam int PAD_W     = TDATA_W - (2 * IDX_W + DATA_W);

  // Bit offsets inside tdata, same layout on both sides.
  localparam int ROW_LSB   = 0;
  localparam int COL_LSB   = ROW_LSB + IDX_W;
  localparam int VAL_LSB   = COL_LSB + IDX_W;

  // Configuration port.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 4;
  localparam int DIM_RESET = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

  // Request kinds carried on s_axis_tuser.
  localparam logic [KIND_W-1:0] KIND_LOAD_A  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 2'd2;

  // Sideband that travels down the multiply-accumulate pipeline.
  typedef struct packed {
    logic             first;   // first inner term of an element
    logic             lastk;   // last inner term of an element
    logic             lastel;  // element is the last of the result matrix
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } tag_t;

endpackage

`default_nettype wire

// File: rtl/core/matrix_multiply_top.sv
// Top level of the matrix multiply block: two element memories and one
// shared multiply-accumulate pipeline. Depends on mm_pkg.
`default_nettype none

// Usage
// The slave stream carries requests. s_axis_tuser holds the kind: load an
// element of A, load an element of B, or compute C. A load writes one word
// of the A or B memory in the cycle it is accepted and gives no result; a
// load with a row or column at or beyond MAX_DIM is dropped, as is kind 3.
// A compute request makes the block emit every element of C = A * B on the
// master stream in row-major order, with tlast on the final element.
// Dimensions come from the rows_a, inner_size and cols_b registers; 0 reads
// as 1 and values above MAX_DIM read as MAX_DIM.
// Timing: one memory read pair is issued per cycle while the pipeline
// advances, one inner term each. The pipeline stages are memory read,
// multiply, accumulate, and saturate into the output register.
// A load leaves the request side open.
// s_axis_tready is low while a compute is in work;
// a request may be accepted while the final result still waits to be taken.
// If the receiver stalls with a result held, the whole pipeline and the
// memory read port freeze until the result is taken; nothing is lost.
// Reset sets all three dimensions to 8 and empties the pipeline. The memories
// are not cleared: read only entries that were loaded since reset.
// Loads and computes never overlap, so a memory entry is never written and
// read in the same cycle.

module matrix_multiply_top #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mm_pkg::CFG_W-1:0]      cfg_data_i,
  // Request stream.
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: row_index[2:0], col_index[5:3], element_value[37:6], zero[39:38]
  input  wire logic [mm_pkg::TDATA_W-1:0]    s_axis_tdata,
  // tuser, low bit up: kind[1:0]
  input  wire logic [mm_pkg::KIND_W-1:0]     s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata, low bit up: out_row[2:0], out_col[5:3], product_value[37:6], zero[39:38]
  output logic [mm_pkg::TDATA_W-1:0]         m_axis_tdata,
  output logic                               m_axis_tlast
);

  localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  // Full-precision sum of MAX_DIM products of two 32-bit signed words.
  localparam int ACC_W  = 2 * mm_pkg::DATA_W + $clog2(MAX_DIM) + 1;
  localparam int DW     = mm_pkg::DATA_W;

  // Register value to dimension minus one, with zero read as one and
  // oversize read as MAX_DIM.
  function automatic logic [DIM_W-1:0] dim_m1(input logic [mm_pkg::CFG_W-1:0] v);
    logic [mm_pkg::CFG_W-1:0] d;
    d = v;
    if (d == '0) begin
      d = mm_pkg::CFG_W'(1);
    end
    if (d > mm_pkg::CFG_W'(MAX_DIM)) begin
      d = mm_pkg::CFG_W'(MAX_DIM);
    end
    return DIM_W'(d - mm_pkg::CFG_W'(1));
  endfunction

  // Request fields.
  logic [mm_pkg::IDX_W-1:0] in_row, in_col;
  logic [DW-1:0]            in_val;
  logic                     s_fire, in_range;
  logic                     wr_a, wr_b, start;
  logic [ADDR_W-1:0]        wr_addr;

  assign in_row   = s_axis_tdata[mm_pkg::ROW_LSB +: mm_pkg::IDX_W];
  assign in_col   = s_axis_tdata[mm_pkg::COL_LSB +: mm_pkg::IDX_W];
  assign in_val   = s_axis_tdata[mm_pkg::VAL_LSB +: DW];
  assign s_fire   = s_axis_tvalid && s_axis_tready;
  assign in_range = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign wr_a     = s_fire && (s_axis_tuser == mm_pkg::KIND_LOAD_A) && in_range;
  assign wr_b     = s_fire && (s_axis_tuser == mm_pkg::KIND_LOAD_B) && in_range;
  assign start    = s_fire && (s_axis_tuser == mm_pkg::KIND_COMPUTE);
  assign wr_addr  = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col));

  // Configuration registers.
  logic [mm_pkg::CFG_W-1:0] rows_a_q, inner_q, cols_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q <= mm_pkg::CFG_W'(mm_pkg::DIM_RESET);
      inner_q  <= mm_pkg::CFG_W'(mm_pkg::DIM_RESET);
      cols_b_q <= mm_pkg::CFG_W'(mm_pkg::DIM_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mm_pkg::CFG_ROWS_A: rows_a_q <= cfg_data_i;
        mm_pkg::CFG_INNER:  inner_q  <= cfg_data_i;
        mm_pkg::CFG_COLS_B: cols_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances unless a result is held and the receiver stalls.
  logic out_valid_q;
  logic adv;
  assign adv = !(out_valid_q && !m_axis_tready);

  // Sequencer: walks row, column, then inner index; one term per cycle while the pipeline advances.
  logic             busy_q, busy_d;
  logic [DIM_W-1:0] r_q, r_d, c_q, c_d, k_q, k_d;
  logic [DIM_W-1:0] nr_q, nc_q, nk_q;
  logic             issue, k_end, c_end, r_end;

  assign issue = busy_q && adv;
  assign k_end = (k_q == nk_q);
  assign c_end = (c_q == nc_q);
  assign r_end = (r_q == nr_q);

  always_comb begin
    busy_d = busy_q;
    r_d    = r_q;
    c_d    = c_q;
    k_d    = k_q;
    if (start) begin
      busy_d = 1'b1;
      r_d    = '0;
      c_d    = '0;
      k_d    = '0;
    end else if (issue) begin
      if (!k_end) begin
        k_d = k_q + DIM_W'(1);
      end else begin
        k_d = '0;
        if (!c_end) begin
          c_d = c_q + DIM_W'(1);
        end else begin
          c_d = '0;
          if (!r_end) begin
            r_d = r_q + DIM_W'(1);
          end else begin
            busy_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      r_q    <= '0;
      c_q    <= '0;
      k_q    <= '0;
    end else begin
      busy_q <= busy_d;
      r_q    <= r_d;
      c_q    <= c_d;
      k_q    <= k_d;
    end
  end

  // Dimensions are captured at the start of a compute.
  always_ff @(posedge clk_i) begin
    if (start) begin
      nr_q <= dim_m1(rows_a_q);
      nk_q <= dim_m1(inner_q);
      nc_q <= dim_m1(cols_b_q);
    end
  end

  // Element memories with a registered read. The read port is enabled
  // only while the pipeline advances so a stalled read holds its data.
  logic [DW-1:0]     mem_a [DEPTH];
  logic [DW-1:0]     mem_b [DEPTH];
  logic [DW-1:0]     rd_a_q, rd_b_q;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

  assign rd_addr_a = ADDR_W'(ADDR_W'(r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q));
  assign rd_addr_b = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(c_q));

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      mem_a[wr_addr] <= in_val;
    end
    if (issue) begin
      rd_a_q <= mem_a[rd_addr_a];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      mem_b[wr_addr] <= in_val;
    end
    if (issue) begin
      rd_b_q <= mem_b[rd_addr_b];
    end
  end

  // Stage 1: tag beside the memory read data.
  logic         v1_q, v2_q, v3_q;
  mm_pkg::tag_t tag1_q, tag2_q, tag3_q;

  always_ff @(posedge clk_i) begin
    if (issue) begin
      tag1_q.first  <= (k_q == '0);
      tag1_q.lastk  <= k_end;
      tag1_q.lastel <= k_end && c_end && r_end;
      tag1_q.row    <= mm_pkg::IDX_W'(r_q);
      tag1_q.col    <= mm_pkg::IDX_W'(c_q);
    end
  end

  // Stage 2: product register.
  logic signed [2*DW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (adv && v1_q) begin
      prod_q <= $signed(rd_a_q) * $signed(rd_b_q);
      tag2_q <= tag1_q;
    end
  end

  // Stage 3: accumulator at full precision.
  logic signed [ACC_W-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (adv && v2_q) begin
      acc_q  <= tag2_q.first ? ACC_W'(prod_q) : acc_q + ACC_W'(prod_q);
      tag3_q <= tag2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= busy_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 4: shift out the fraction (truncating toward minus infinity) and
  // saturate to 32 bits, then load the output register.
  logic signed [ACC_W-1:0] shifted;
  logic [ACC_W-DW:0]       upper;
  logic [DW-1:0]           sat_val;
  logic                    out_load;

  assign shifted = acc_q >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:DW-1];

  always_comb begin
    if ((&upper) || !(|upper)) begin
      sat_val = shifted[DW-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_val = {1'b1, {(DW-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(DW-1){1'b1}}};
    end
  end

  assign out_load = adv && v3_q && tag3_q.lastk;

  logic [mm_pkg::TDATA_W-1:0] out_data_q;
  logic                       out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {{mm_pkg::PAD_W{1'b0}}, sat_val, tag3_q.col, tag3_q.row};
      out_last_q <= tag3_q.lastel;
    end
  end

  assign s_axis_tready = !(busy_q || v1_q || v2_q || v3_q);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// File: rtl/core/mm_checker.sv
// Port-level checker for the matrix multiply top level, with its bind.
// Depends on mm_pkg; attaches to matrix_multiply_top.
`default_nettype none

module mm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid,
  input wire logic                          s_axis_tready,
  input wire logic [mm_pkg::KIND_W-1:0]     s_axis_tuser,
  input wire logic                          m_axis_tvalid,
  input wire logic                          m_axis_tready,
  input wire logic [mm_pkg::TDATA_W-1:0]    m_axis_tdata,
  input wire logic                          m_axis_tlast
);

  logic s_fire, is_compute;
  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign is_compute = (s_axis_tuser == mm_pkg::KIND_COMPUTE);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // A compute request, once taken, closes the request side.
  a_compute_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && is_compute |=> !s_axis_tready)
    else $error("request accepted right after a compute request");

  // Loads and unused kinds never close the request side.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !is_compute |=> s_axis_tready)
    else $error("request side closed after a load");

  // An open request side stays open until a compute request is taken.
  a_ready_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready && !(s_fire && is_compute) |=> s_axis_tready)
    else $error("request side closed without a compute request");

endmodule

bind matrix_multiply_top mm_checker u_mm_checker (.*);

`default_nettype wire
